### design/bba_pkg.sv
package bba_pkg;

  localparam int MAX_ORDER_DEF = 10;
  localparam int ID_BITS_DEF   = 16;

  localparam int CFG_W  = 4;
  localparam int PID_W  = 16;
  localparam int SIZE_W = 11;
  localparam int STAT_W = 2;
  localparam int ORD_W  = 5;
  localparam int K_W    = 4;

  localparam logic [CFG_W-1:0] TOTAL_ORDER_RST = 4'd10;

  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_OCC   = 2'd1,
    ST_SPLIT = 2'd2
  } node_st_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOMEM = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOID  = 2'd2;

  // Smallest k with 2^k >= size, for a nonzero size.
  function automatic logic [K_W-1:0] size_order(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] v;
    logic [K_W-1:0]    k;
    v = size - SIZE_W'(1);
    k = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (v[i]) begin
        k = K_W'(i + 1);
      end
    end
    return k;
  endfunction

endpackage

### design/bba_node_mem.sv
module bba_node_mem #(
  parameter int NW  = bba_pkg::MAX_ORDER_DEF + 1,
  parameter int IDW = bba_pkg::ID_BITS_DEF
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [NW-1:0]     rd_addr,
  output bba_pkg::node_st_t rd_state,
  output logic [IDW-1:0]    rd_owner,
  input  logic              st_we,
  input  logic              own_we,
  input  logic [NW-1:0]     wr_addr,
  input  bba_pkg::node_st_t wr_state,
  input  logic [IDW-1:0]    wr_owner
);

  localparam int DEPTH = 1 << NW;

  bba_pkg::node_st_t state_mem [DEPTH];
  logic [IDW-1:0]    owner_mem [DEPTH];

  bba_pkg::node_st_t rd_state_r;
  logic [IDW-1:0]    rd_owner_r;

  always_ff @(posedge clk) begin
    if (st_we) begin
      state_mem[wr_addr] <= wr_state;
    end
    if (own_we) begin
      owner_mem[wr_addr] <= wr_owner;
    end
    if (rd_en) begin
      rd_state_r <= state_mem[rd_addr];
      rd_owner_r <= owner_mem[rd_addr];
    end
  end

  assign rd_state = rd_state_r;
  assign rd_owner = rd_owner_r;

endmodule

### design/buddy_block_allocator_top.sv
// A rejected allocate (size zero or too large) goes straight to the result state. Other items
// walk the tree, one memory access per cycle: allocate reads and checks each node, backs out
// of nodes that cannot take the block, splits each level and occupies the target; free reads
// and checks each node visited and reads both children of each split node for the merge check.
// One item is handled at a time; the next may be accepted while a result waits.
// Synchronous active-low reset sets total_order to 10 and then marks the root free in INIT.
module buddy_block_allocator_top #(
  parameter int MAX_ORDER = bba_pkg::MAX_ORDER_DEF,
  parameter int ID_BITS   = bba_pkg::ID_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bba_pkg::CFG_W-1:0]  cfg_total_order,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_opcode,
  input  logic [bba_pkg::PID_W-1:0]  in_process_id,
  input  logic [bba_pkg::SIZE_W-1:0] in_request_size,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bba_pkg::STAT_W-1:0] out_status
);

  // Node 1 is the root; node i has children 2i and 2i+1.
  localparam int NW = MAX_ORDER + 1;

  // Only nodes reachable from the root through split nodes are ever read, and
  // splitting a node always writes its children. Clearing the tree therefore
  // only needs the root marked free, which the INIT state does.
  typedef enum logic [13:0] {
    S_INIT  = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_A_RD  = 14'b00000000000100,
    S_A_CHK = 14'b00000000001000,
    S_A_SPL = 14'b00000000010000,
    S_A_RCL = 14'b00000000100000,
    S_A_OCC = 14'b00000001000000,
    S_A_FL  = 14'b00000010000000,
    S_R_RD  = 14'b00000100000000,
    S_R_CHK = 14'b00001000000000,
    S_R_RET = 14'b00010000000000,
    S_R_RDR = 14'b00100000000000,
    S_R_MRG = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } fsm_t;

  fsm_t                        state_r, state_nxt;
  logic [bba_pkg::CFG_W-1:0]   tot_r, tot_nxt;
  logic [NW-1:0]               idx_r, idx_nxt;
  logic [bba_pkg::ORD_W-1:0]   ord_r, ord_nxt;
  logic [bba_pkg::K_W-1:0]     k_r, k_nxt;
  logic [ID_BITS-1:0]          id_r, id_nxt;
  logic                        any_r, any_nxt;
  logic                        lfree_r, lfree_nxt;
  logic [bba_pkg::STAT_W-1:0]  stat_r, stat_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [bba_pkg::STAT_W-1:0]  out_status_r, out_status_nxt;

  logic                        rd_en;
  logic [NW-1:0]               rd_addr;
  bba_pkg::node_st_t           rd_state;
  logic [ID_BITS-1:0]          rd_owner;
  logic                        st_we;
  logic                        own_we;
  logic [NW-1:0]               wr_addr;
  bba_pkg::node_st_t           wr_state;

  logic [bba_pkg::ORD_W-1:0]   eff_order;
  logic [bba_pkg::K_W-1:0]     req_k;
  logic [NW-1:0]               root_idx;
  logic [NW-1:0]               left_idx;
  logic [NW-1:0]               right_idx;
  logic                        cfg_acc;
  logic                        in_acc;

  // An order register above the tree depth acts as the full depth.
  assign eff_order = (int'(tot_r) > MAX_ORDER) ? bba_pkg::ORD_W'(MAX_ORDER)
                                               : bba_pkg::ORD_W'(tot_r);
  assign req_k     = bba_pkg::size_order(in_request_size);
  assign root_idx  = NW'(1);
  assign left_idx  = {idx_r[NW-2:0], 1'b0};
  assign right_idx = {idx_r[NW-2:0], 1'b1};

  // Configuration has priority over an item offered in the same cycle.
  assign cfg_ready = (state_r == S_IDLE);
  assign in_ready  = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_acc    = in_valid && in_ready;

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    tot_nxt        = tot_r;
    idx_nxt        = idx_r;
    ord_nxt        = ord_r;
    k_nxt          = k_r;
    id_nxt         = id_r;
    any_nxt        = any_r;
    lfree_nxt      = lfree_r;
    stat_nxt       = stat_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    rd_en          = 1'b0;
    rd_addr        = idx_r;
    st_we          = 1'b0;
    own_we         = 1'b0;
    wr_addr        = idx_r;
    wr_state       = bba_pkg::ST_FREE;

    unique case (state_r)
      S_INIT: begin
        st_we     = 1'b1;
        wr_addr   = root_idx;
        wr_state  = bba_pkg::ST_FREE;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_acc) begin
          tot_nxt   = cfg_total_order;
          state_nxt = S_INIT;
        end else if (in_acc) begin
          id_nxt  = ID_BITS'(in_process_id);
          k_nxt   = req_k;
          idx_nxt = root_idx;
          ord_nxt = eff_order;
          any_nxt = 1'b0;
          if (in_opcode == bba_pkg::OP_FREE) begin
            state_nxt = S_R_RD;
          end else if ((in_request_size == '0) || ({1'b0, req_k} > eff_order)) begin
            stat_nxt  = bba_pkg::STAT_NOMEM;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_A_RD;
          end
        end
      end

      // Allocation: depth-first, left first, through split nodes.
      S_A_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_A_CHK;
      end
      S_A_CHK: begin
        if (ord_r == {1'b0, k_r}) begin
          if (rd_state == bba_pkg::ST_FREE) begin
            st_we     = 1'b1;
            own_we    = 1'b1;
            wr_state  = bba_pkg::ST_OCC;
            stat_nxt  = bba_pkg::STAT_OK;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_A_FL;
          end
        end else if (rd_state == bba_pkg::ST_SPLIT) begin
          idx_nxt   = left_idx;
          ord_nxt   = ord_r - 1'b1;
          state_nxt = S_A_RD;
        end else if (rd_state == bba_pkg::ST_FREE) begin
          // A free node above the target order always leads to a success.
          state_nxt = S_A_SPL;
        end else begin
          state_nxt = S_A_FL;
        end
      end
      S_A_SPL: begin
        st_we     = 1'b1;
        wr_state  = bba_pkg::ST_SPLIT;
        state_nxt = S_A_RCL;
      end
      S_A_RCL: begin
        st_we    = 1'b1;
        wr_addr  = right_idx;
        wr_state = bba_pkg::ST_FREE;
        idx_nxt  = left_idx;
        ord_nxt  = ord_r - 1'b1;
        if ((ord_r - 1'b1) == {1'b0, k_r}) begin
          state_nxt = S_A_OCC;
        end else begin
          state_nxt = S_A_SPL;
        end
      end
      S_A_OCC: begin
        st_we     = 1'b1;
        own_we    = 1'b1;
        wr_state  = bba_pkg::ST_OCC;
        stat_nxt  = bba_pkg::STAT_OK;
        state_nxt = S_DONE;
      end
      S_A_FL: begin
        if (idx_r == root_idx) begin
          stat_nxt  = bba_pkg::STAT_NOMEM;
          state_nxt = S_DONE;
        end else if (!idx_r[0]) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_A_RD;
        end else begin
          idx_nxt = idx_r >> 1;
          ord_nxt = ord_r + 1'b1;
        end
      end

      // Release: post-order walk over split nodes, merging free buddy pairs.
      S_R_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_R_CHK;
      end
      S_R_CHK: begin
        if ((rd_state == bba_pkg::ST_OCC) && (rd_owner == id_r)) begin
          st_we     = 1'b1;
          wr_state  = bba_pkg::ST_FREE;
          any_nxt   = 1'b1;
          state_nxt = S_R_RET;
        end else if ((rd_state == bba_pkg::ST_SPLIT) && (ord_r != '0)) begin
          idx_nxt   = left_idx;
          ord_nxt   = ord_r - 1'b1;
          state_nxt = S_R_RD;
        end else begin
          state_nxt = S_R_RET;
        end
      end
      S_R_RET: begin
        if (idx_r == root_idx) begin
          stat_nxt  = any_r ? bba_pkg::STAT_OK : bba_pkg::STAT_NOID;
          state_nxt = S_DONE;
        end else if (!idx_r[0]) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_R_RD;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = {idx_r[NW-1:1], 1'b0};
          idx_nxt   = idx_r >> 1;
          ord_nxt   = ord_r + 1'b1;
          state_nxt = S_R_RDR;
        end
      end
      S_R_RDR: begin
        lfree_nxt = (rd_state == bba_pkg::ST_FREE);
        rd_en     = 1'b1;
        rd_addr   = right_idx;
        state_nxt = S_R_MRG;
      end
      S_R_MRG: begin
        if (lfree_r && (rd_state == bba_pkg::ST_FREE)) begin
          st_we    = 1'b1;
          wr_state = bba_pkg::ST_FREE;
          any_nxt  = 1'b1;
        end
        state_nxt = S_R_RET;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = stat_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      tot_r       <= bba_pkg::TOTAL_ORDER_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tot_r       <= tot_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    ord_r        <= ord_nxt;
    k_r          <= k_nxt;
    id_r         <= id_nxt;
    any_r        <= any_nxt;
    lfree_r      <= lfree_nxt;
    stat_r       <= stat_nxt;
    out_status_r <= out_status_nxt;
  end

  bba_node_mem #(
    .NW  (NW),
    .IDW (ID_BITS)
  ) u_mem (
    .clk      (clk),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_state (rd_state),
    .rd_owner (rd_owner),
    .st_we    (st_we),
    .own_we   (own_we),
    .wr_addr  (wr_addr),
    .wr_state (wr_state),
    .wr_owner (id_r)
  );

`ifndef SYNTHESIS
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && st_we))
    else $error("node memory read and write in the same cycle");

  a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("item accepted but no work started");

  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_acc |=> (state_r == S_INIT))
    else $error("configuration write did not clear the tree");

  a_order_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_A_CHK || state_r == S_R_CHK) |-> (int'(ord_r) <= MAX_ORDER))
    else $error("walk order above tree depth");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r != 2'd3))
    else $error("invalid status code");
`endif

endmodule

### bench/buddy_block_allocator_top_test.sv
`timescale 1ns / 1ps

module buddy_block_allocator_top_test;

  localparam int NODES      = 1 << (bba_pkg::MAX_ORDER_DEF + 1);
  localparam int STALL_MAX  = 60000;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [bba_pkg::CFG_W-1:0]    cfg_total_order;
  logic                         in_valid;
  logic                         in_ready;
  logic                         in_opcode;
  logic [bba_pkg::PID_W-1:0]    in_process_id;
  logic [bba_pkg::SIZE_W-1:0]   in_request_size;
  logic                         out_valid;
  logic                         out_ready;
  logic [bba_pkg::STAT_W-1:0]   out_status;

  buddy_block_allocator_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_total_order (cfg_total_order),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_process_id   (in_process_id),
    .in_request_size (in_request_size),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status)
  );

  // Free-running 2 ns clock.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the allocator tree, kept in step with every accepted item.
  bba_pkg::node_st_t          tree_st [NODES];
  logic [bba_pkg::PID_W-1:0]  tree_owner [NODES];
  logic [bba_pkg::CFG_W-1:0]  shadow_order;

  // Status codes that the block owes us, oldest first.
  logic [bba_pkg::STAT_W-1:0] status_due [$];

  int  mismatches;
  int  results_seen;
  int  allocs_sent;
  int  frees_sent;
  int  cfg_writes;
  bit  calm;          // when set, neither side inserts idle cycles
  int  stall_cycles;

  function automatic int live_order();
    return (shadow_order > bba_pkg::MAX_ORDER_DEF) ? bba_pkg::MAX_ORDER_DEF
                                                   : int'(shadow_order);
  endfunction

  function automatic void wipe_tree();
    for (int i = 0; i < NODES; i++) begin
      tree_st[i]    = bba_pkg::ST_FREE;
      tree_owner[i] = '0;
    end
  endfunction

  // Left-first search for the smallest order that holds the size.
  function automatic bit place_block(int idx, int ord, int size,
                                     logic [bba_pkg::PID_W-1:0] id);
    int full;
    int half;
    full = 1 << ord;
    half = (ord != 0) ? (full >> 1) : 0;
    idx  = idx & (NODES - 1);
    if (size > full) return 1'b0;
    if (size > half) begin
      if (tree_st[idx] == bba_pkg::ST_FREE) begin
        tree_st[idx]    = bba_pkg::ST_OCC;
        tree_owner[idx] = id;
        return 1'b1;
      end
      return 1'b0;
    end
    if (ord == 0 || tree_st[idx] == bba_pkg::ST_OCC) return 1'b0;
    if (tree_st[idx] == bba_pkg::ST_FREE) begin
      tree_st[idx] = bba_pkg::ST_SPLIT;
      tree_st[(2 * idx) & (NODES - 1)]     = bba_pkg::ST_FREE;
      tree_st[(2 * idx + 1) & (NODES - 1)] = bba_pkg::ST_FREE;
    end
    if (place_block(2 * idx, ord - 1, size, id)) return 1'b1;
    return place_block(2 * idx + 1, ord - 1, size, id);
  endfunction

  // Releases every block of an id below idx and merges free buddies on the way up.
  function automatic bit release_owner(int idx, int ord, logic [bba_pkg::PID_W-1:0] id);
    int lft;
    int rgt;
    bit got_l;
    bit got_r;
    idx = idx & (NODES - 1);
    if (tree_st[idx] == bba_pkg::ST_OCC && tree_owner[idx] == id) begin
      tree_st[idx] = bba_pkg::ST_FREE;
      return 1'b1;
    end
    if (tree_st[idx] != bba_pkg::ST_SPLIT || ord == 0) return 1'b0;
    lft   = (2 * idx) & (NODES - 1);
    rgt   = (2 * idx + 1) & (NODES - 1);
    got_l = release_owner(lft, ord - 1, id);
    got_r = release_owner(rgt, ord - 1, id);
    if (tree_st[lft] == bba_pkg::ST_FREE && tree_st[rgt] == bba_pkg::ST_FREE) begin
      tree_st[idx] = bba_pkg::ST_FREE;
      return 1'b1;
    end
    return got_l || got_r;
  endfunction

  function automatic logic [bba_pkg::STAT_W-1:0] alloc_status(
      logic op, logic [bba_pkg::PID_W-1:0] id, logic [bba_pkg::SIZE_W-1:0] size);
    if (op == bba_pkg::OP_ALLOC) begin
      if (size == '0) return bba_pkg::STAT_NOMEM;
      return place_block(1, live_order(), int'(size), id) ? bba_pkg::STAT_OK
                                                          : bba_pkg::STAT_NOMEM;
    end
    return release_owner(1, live_order(), id) ? bba_pkg::STAT_OK : bba_pkg::STAT_NOID;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  function automatic int idle_burst();
    if (calm) return 0;
    if ($urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 17);
  endfunction

  // Sends one item; valid stays high across back-to-back items.
  task automatic send_item(logic op, logic [bba_pkg::PID_W-1:0] id,
                           logic [bba_pkg::SIZE_W-1:0] size);
    int gap;
    gap = idle_burst();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_process_id   <= id;
    in_request_size <= size;
    do @(posedge clk); while (!in_ready);
    status_due.push_back(alloc_status(op, id, size));
    if (op == bba_pkg::OP_ALLOC) allocs_sent++;
    else frees_sent++;
  endtask

  // Waits until every result is back, then lets the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_order(logic [bba_pkg::CFG_W-1:0] ord);
    drain();
    cfg_valid       <= 1'b1;
    cfg_total_order <= ord;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    shadow_order = ord;
    wipe_tree();
    cfg_writes++;
  endtask

  // The receiver stalls in bursts; every accepted result is checked here.
  int ready_hold;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      ready_hold <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (status_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result, status %0d", out_status));
        end else begin
          if (out_status !== status_due[0])
            report_mismatch($sformatf("status %0d, wanted %0d", out_status, status_due[0]));
          void'(status_due.pop_front());
        end
      end
      if (calm) begin
        out_ready <= 1'b1;
      end else if (ready_hold > 0) begin
        ready_hold <= ready_hold - 1;
        out_ready  <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        ready_hold <= $urandom_range(0, 16);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any handshake ends the run.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
        || !rst_n) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Extremes of every field on the reset setting, then the smallest tree and an order setting of 15.
  task automatic test_directed();
    send_item(bba_pkg::OP_ALLOC, 16'h0001, 11'd0);       // zero size is refused
    send_item(bba_pkg::OP_ALLOC, 16'h0001, 11'd2047);    // larger than the whole memory
    send_item(bba_pkg::OP_ALLOC, 16'h0001, 11'd1025);
    send_item(bba_pkg::OP_FREE,  16'hFFFF, 11'd0);       // unknown id on an empty tree
    send_item(bba_pkg::OP_ALLOC, 16'hFFFF, 11'd1024);    // whole memory
    send_item(bba_pkg::OP_ALLOC, 16'h0002, 11'd1);       // root occupied
    send_item(bba_pkg::OP_FREE,  16'hFFFF, 11'd2047);
    send_item(bba_pkg::OP_ALLOC, 16'h0000, 11'd1);       // splits all the way to a leaf
    send_item(bba_pkg::OP_ALLOC, 16'h0003, 11'd1);       // right buddy of that leaf
    send_item(bba_pkg::OP_ALLOC, 16'h0004, 11'd512);
    send_item(bba_pkg::OP_ALLOC, 16'h0005, 11'd512);     // exact fit busy
    send_item(bba_pkg::OP_ALLOC, 16'h0005, 11'd2);
    send_item(bba_pkg::OP_FREE,  16'h0000, 11'd0);
    send_item(bba_pkg::OP_FREE,  16'h0003, 11'd0);
    send_item(bba_pkg::OP_FREE,  16'h0005, 11'd0);
    send_item(bba_pkg::OP_FREE,  16'h0004, 11'd0);       // everything merges back
    send_item(bba_pkg::OP_FREE,  16'h0004, 11'd0);
    write_order(4'd0);
    send_item(bba_pkg::OP_ALLOC, 16'h0007, 11'd2);
    send_item(bba_pkg::OP_ALLOC, 16'h0007, 11'd1);
    send_item(bba_pkg::OP_ALLOC, 16'h0008, 11'd1);
    send_item(bba_pkg::OP_FREE,  16'h0007, 11'd0);
    write_order(4'd15);                                  // acts as the largest order
    send_item(bba_pkg::OP_ALLOC, 16'h0009, 11'd1024);
    send_item(bba_pkg::OP_FREE,  16'h0009, 11'd0);
  endtask

  // Random allocate and free items over one tree setting. Ids come mostly
  // from a small pool so that frees find blocks to release.
  task automatic test_random_phase(logic [bba_pkg::CFG_W-1:0] ord, int count);
    int eff;
    logic [bba_pkg::PID_W-1:0]  id;
    logic [bba_pkg::SIZE_W-1:0] size;
    write_order(ord);
    eff = live_order();
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 7) == 0) id = bba_pkg::PID_W'($urandom_range(0, 65535));
      else id = bba_pkg::PID_W'($urandom_range(0, 5))
                ^ ($urandom_range(0, 1) ? 16'hA5F0 : 16'h0000);
      if ($urandom_range(0, 12) == 0) size = bba_pkg::SIZE_W'($urandom_range(0, 2047));
      else size = bba_pkg::SIZE_W'($urandom_range(1, ((1 << eff) >> $urandom_range(0, eff)) + 1));
      send_item(($urandom_range(0, 3) == 0) ? bba_pkg::OP_FREE : bba_pkg::OP_ALLOC, id, size);
    end
  endtask

  task automatic test_random();
    test_random_phase(4'd3, 200);
    test_random_phase(4'd1, 120);
    test_random_phase(4'd5, 250);
    test_random_phase(4'd10, 150);
    test_random_phase(4'd0, 80);
    test_random_phase(4'd4, 250);
    test_random_phase(4'd2, 150);
    test_random_phase(4'd7, 200);
    test_random_phase(4'd12, 80);
    calm = 1'b1;                                 // last stretch runs without idling
    test_random_phase(4'd6, 270);
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_total_order = '0;
    in_valid        = 1'b0;
    in_opcode       = bba_pkg::OP_ALLOC;
    in_process_id   = '0;
    in_request_size = '0;
    mismatches      = 0;
    results_seen    = 0;
    allocs_sent     = 0;
    frees_sent      = 0;
    cfg_writes      = 0;
    calm            = 1'b0;
    stall_cycles    = 0;
    shadow_order    = bba_pkg::TOTAL_ORDER_RST;
    wipe_tree();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random();
    drain();

    if (status_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", status_due.size()));
    $display("covered %0d allocates and %0d frees over %0d tree settings, %0d results checked",
             allocs_sent, frees_sent, cfg_writes + 1, results_seen);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
